>>> rtl/oaf_pkg.sv
// ----------------------------------------------------------------------------
// oaf_pkg
// Shared types and constants for the obstacle avoidance force unit.
// ----------------------------------------------------------------------------
package oaf_pkg;

    localparam int QBITS       = 13;
    localparam int RADIUS_W    = 15;
    localparam int FORCE_W     = 24;
    localparam int AVOID_W     = 21;
    localparam int SMOOTH_K    = 12288;
    localparam logic [RADIUS_W-1:0] BOID_RADIUS_RST = 15'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_CHECK,
        ST_DIV,
        ST_SMA,
        ST_SMB,
        ST_MULA,
        ST_MULB,
        ST_ADD,
        ST_EMIT
    } seq_state_t;

endpackage

>>> rtl/oaf_front.sv
// ----------------------------------------------------------------------------
// oaf_front
// Forms per-axis offset magnitudes and signs for one input word.
// ----------------------------------------------------------------------------
module oaf_front #(
    parameter int W = 16
) (
    input  logic signed [W-1:0]                 boid_x,
    input  logic signed [W-1:0]                 boid_y,
    input  logic signed [W-1:0]                 boid_z,
    input  logic signed [W-1:0]                 obstacle_x,
    input  logic signed [W-1:0]                 obstacle_y,
    input  logic signed [W-1:0]                 obstacle_z,
    input  logic [oaf_pkg::RADIUS_W-1:0]        obstacle_radius,
    input  logic                                last_obstacle,
    output logic [3*(W+1)+3+oaf_pkg::RADIUS_W:0] entry
);

    localparam int MW = W + 1;

    logic signed [MW-1:0] dx, dy, dz;
    logic [MW-1:0]        mx, my, mz;

    assign dx = MW'(obstacle_x) - MW'(boid_x);
    assign dy = MW'(obstacle_y) - MW'(boid_y);
    assign dz = MW'(obstacle_z) - MW'(boid_z);

    assign mx = dx[MW-1] ? MW'(-dx) : MW'(dx);
    assign my = dy[MW-1] ? MW'(-dy) : MW'(dy);
    assign mz = dz[MW-1] ? MW'(-dz) : MW'(dz);

    assign entry = {last_obstacle, obstacle_radius, dz[MW-1], dy[MW-1], dx[MW-1], mz, my, mx};

endmodule

>>> rtl/oaf_queue.sv
// ----------------------------------------------------------------------------
// oaf_queue
// Two-entry queue between the front and the sequencer.
// ----------------------------------------------------------------------------
module oaf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/oaf_seq.sv
// ----------------------------------------------------------------------------
// oaf_seq
// Sequencer: distance root, shared divider, smoothstep and saturating sums.
// ----------------------------------------------------------------------------
module oaf_seq #(
    parameter int W = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [oaf_pkg::RADIUS_W-1:0]         boid_radius,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  logic [3*(W+1)+3+oaf_pkg::RADIUS_W:0] q_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [oaf_pkg::FORCE_W-1:0]   force_x,
    output logic signed [oaf_pkg::FORCE_W-1:0]   force_y,
    output logic signed [oaf_pkg::FORCE_W-1:0]   force_z
);

    localparam int MW   = W + 1;
    localparam int RW   = W + 6;
    localparam int RADW = 2 * RW;
    localparam int AVW  = oaf_pkg::AVOID_W;
    localparam int DVW  = (RW > AVW) ? RW : AVW;
    localparam int UNW  = MW + 16;
    localparam int TNW  = DVW + 12;
    localparam int NW   = (UNW > TNW) ? UNW : TNW;
    localparam int DSW  = DVW + oaf_pkg::QBITS - 1;
    localparam int CMW  = (NW > DSW) ? NW : DSW;
    localparam int CW   = ($clog2(RW) > 4) ? $clog2(RW) : 4;
    localparam int QB   = oaf_pkg::QBITS;
    localparam int RDW  = oaf_pkg::RADIUS_W;
    localparam int FW   = oaf_pkg::FORCE_W;
    localparam int CNW  = 21;
    localparam int SW   = FW + 2;

    oaf_pkg::seq_state_t state_reg, state_next;

    logic [MW-1:0]        mag_reg [3];
    logic [2:0]           neg_reg;
    logic [RDW-1:0]       rad_reg;
    logic                 last_reg;
    logic                 inside_reg, inside_next;
    logic [1:0]           axis_reg, axis_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [RADW-1:0]      rdc_reg, rdc_next;
    logic [RW+1:0]        srem_reg, srem_next;
    logic [RW-1:0]        root_reg, root_next;
    logic [NW-1:0]        drem_reg, drem_next;
    logic [DSW-1:0]       dsh_reg, dsh_next;
    logic [QB-1:0]        q_reg, q_next;
    logic [QB-1:0]        u_reg [3];
    logic [QB-1:0]        t_reg;
    logic [2*QB-1:0]      tt_reg;
    logic [QB-1:0]        s_reg;
    logic [QB+RDW-1:0]    p_reg;
    logic [CNW-1:0]       c_reg;
    logic signed [FW-1:0] sum_reg [3];
    logic signed [FW-1:0] fx_reg, fy_reg, fz_reg;
    logic                 out_valid_reg;

    logic [2*MW-1:0]      sq;
    logic [RW+3:0]        cand, trial;
    logic [DVW-1:0]       dist_x, avoid_x, rad12_x;
    logic                 skip;
    logic [CMW-1:0]       cmp_rem, cmp_sh;
    logic                 div_ge;
    logic [QB-1:0]        q_done;
    logic [QB:0]          kfac;
    logic [3*QB:0]        sprod;
    logic [QB+RDW+QB-1:0] cprod;
    logic [CNW-1:0]       contrib;
    logic signed [SW-1:0] acc;
    logic                 can_emit;

    assign q_ready   = (state_reg == oaf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign force_x   = fx_reg;
    assign force_y   = fy_reg;
    assign force_z   = fz_reg;
    assign can_emit  = !out_valid_reg || out_ready;

    assign sq    = mag_reg[axis_reg] * mag_reg[axis_reg];
    assign cand  = {srem_reg, rdc_reg[RADW-1 -: 2]};
    assign trial = (RW+4)'({root_reg, 2'b01});

    assign dist_x  = DVW'(root_reg);
    assign avoid_x = DVW'({(17'(boid_radius) + 17'({rad_reg, 1'b0})), 4'b0000});
    assign rad12_x = DVW'({rad_reg, 4'b0000});
    assign skip    = (root_reg == '0) || (dist_x > avoid_x);

    assign cmp_rem = CMW'(drem_reg);
    assign cmp_sh  = CMW'(dsh_reg);
    assign div_ge  = (cmp_rem >= cmp_sh);
    assign q_done  = {q_reg[QB-2:0], div_ge};

    assign kfac    = (QB+1)'(oaf_pkg::SMOOTH_K) - (QB+1)'({t_reg, 1'b0});
    assign sprod   = tt_reg * kfac;
    assign cprod   = p_reg * s_reg;
    assign contrib = inside_reg ? CNW'(u_reg[axis_reg]) : c_reg;

    always_comb
    begin
        acc = neg_reg[axis_reg] ? (SW'(sum_reg[axis_reg]) + SW'(contrib))
                                : (SW'(sum_reg[axis_reg]) - SW'(contrib));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oaf_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = oaf_pkg::ST_SQ;
                end
            end
            oaf_pkg::ST_SQ:
            begin
                if (axis_reg == 2'd2)
                begin
                    state_next = oaf_pkg::ST_SQRT;
                end
            end
            oaf_pkg::ST_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = oaf_pkg::ST_CHECK;
                end
            end
            oaf_pkg::ST_CHECK:
            begin
                if (skip)
                begin
                    state_next = last_reg ? oaf_pkg::ST_EMIT : oaf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = oaf_pkg::ST_DIV;
                end
            end
            oaf_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (axis_reg == 2'd3)
                    begin
                        state_next = oaf_pkg::ST_SMA;
                    end
                    else if (axis_reg == 2'd2 && inside_reg)
                    begin
                        state_next = oaf_pkg::ST_ADD;
                    end
                end
            end
            oaf_pkg::ST_SMA:
            begin
                state_next = oaf_pkg::ST_SMB;
            end
            oaf_pkg::ST_SMB:
            begin
                state_next = oaf_pkg::ST_MULA;
            end
            oaf_pkg::ST_MULA:
            begin
                state_next = oaf_pkg::ST_MULB;
            end
            oaf_pkg::ST_MULB:
            begin
                state_next = oaf_pkg::ST_ADD;
            end
            oaf_pkg::ST_ADD:
            begin
                if (axis_reg == 2'd2)
                begin
                    state_next = last_reg ? oaf_pkg::ST_EMIT : oaf_pkg::ST_IDLE;
                end
                else if (!inside_reg)
                begin
                    state_next = oaf_pkg::ST_MULA;
                end
            end
            oaf_pkg::ST_EMIT:
            begin
                if (can_emit)
                begin
                    state_next = oaf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oaf_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        axis_next   = axis_reg;
        cnt_next    = cnt_reg;
        rdc_next    = rdc_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        drem_next   = drem_reg;
        dsh_next    = dsh_reg;
        q_next      = q_reg;
        inside_next = inside_reg;
        unique case (state_reg)
            oaf_pkg::ST_IDLE:
            begin
                axis_next = 2'd0;
                rdc_next  = '0;
            end
            oaf_pkg::ST_SQ:
            begin
                rdc_next  = rdc_reg + RADW'({sq, 8'h00});
                axis_next = axis_reg + 2'd1;
                cnt_next  = CW'(RW - 1);
                srem_next = '0;
                root_next = '0;
            end
            oaf_pkg::ST_SQRT:
            begin
                rdc_next = rdc_reg << 2;
                cnt_next = cnt_reg - CW'(1);
                if (cand >= trial)
                begin
                    srem_next = (RW+2)'(cand - trial);
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    srem_next = cand[RW+1:0];
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
            end
            oaf_pkg::ST_CHECK:
            begin
                inside_next = (dist_x < rad12_x);
                axis_next   = 2'd0;
                drem_next   = NW'({mag_reg[0], 16'h0000});
                dsh_next    = {dist_x, {(QB-1){1'b0}}};
                q_next      = '0;
                cnt_next    = CW'(QB - 1);
            end
            oaf_pkg::ST_DIV:
            begin
                q_next   = q_done;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (div_ge)
                begin
                    drem_next = NW'(cmp_rem - cmp_sh);
                end
                if (cnt_reg == '0)
                begin
                    q_next   = '0;
                    cnt_next = CW'(QB - 1);
                    if (axis_reg == 2'd2 && inside_reg)
                    begin
                        axis_next = 2'd0;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        axis_next = 2'd3;
                        drem_next = NW'({avoid_x - dist_x, 12'h000});
                        dsh_next  = {avoid_x, {(QB-1){1'b0}}};
                    end
                    else if (axis_reg != 2'd3)
                    begin
                        axis_next = axis_reg + 2'd1;
                        drem_next = NW'({mag_reg[axis_reg + 2'd1], 16'h0000});
                        dsh_next  = {dist_x, {(QB-1){1'b0}}};
                    end
                    else
                    begin
                        axis_next = 2'd0;
                    end
                end
            end
            oaf_pkg::ST_ADD:
            begin
                axis_next = axis_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oaf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == oaf_pkg::ST_EMIT && can_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == oaf_pkg::ST_ADD)
            begin
                if (acc > SW'((1 << (FW - 1)) - 1))
                begin
                    sum_reg[axis_reg] <= FW'((1 << (FW - 1)) - 1);
                end
                else if (acc < -SW'(1 << (FW - 1)))
                begin
                    sum_reg[axis_reg] <= FW'(-SW'(1 << (FW - 1)));
                end
                else
                begin
                    sum_reg[axis_reg] <= FW'(acc);
                end
            end
            if (state_reg == oaf_pkg::ST_EMIT && can_emit)
            begin
                sum_reg[0]    <= '0;
                sum_reg[1]    <= '0;
                sum_reg[2]    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg   <= axis_next;
        cnt_reg    <= cnt_next;
        rdc_reg    <= rdc_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        inside_reg <= inside_next;
        if (state_reg == oaf_pkg::ST_IDLE && q_valid)
        begin
            mag_reg[0] <= q_data[MW-1:0];
            mag_reg[1] <= q_data[2*MW-1:MW];
            mag_reg[2] <= q_data[3*MW-1:2*MW];
            neg_reg    <= q_data[3*MW+2:3*MW];
            rad_reg    <= q_data[3*MW+3+RDW-1:3*MW+3];
            last_reg   <= q_data[3*MW+3+RDW];
        end
        if (state_reg == oaf_pkg::ST_DIV && cnt_reg == '0)
        begin
            if (axis_reg == 2'd3)
            begin
                t_reg <= q_done;
            end
            else
            begin
                u_reg[axis_reg] <= q_done;
            end
        end
        if (state_reg == oaf_pkg::ST_SMA)
        begin
            tt_reg <= t_reg * t_reg;
        end
        if (state_reg == oaf_pkg::ST_SMB)
        begin
            s_reg <= sprod[24 +: QB];
        end
        if (state_reg == oaf_pkg::ST_MULA)
        begin
            p_reg <= u_reg[axis_reg] * rad_reg;
        end
        if (state_reg == oaf_pkg::ST_MULB)
        begin
            c_reg <= cprod[20 +: CNW];
        end
        if (state_reg == oaf_pkg::ST_EMIT && can_emit)
        begin
            fx_reg <= sum_reg[0];
            fy_reg <= sum_reg[1];
            fz_reg <= sum_reg[2];
        end
    end

endmodule

>>> rtl/obstacle_avoidance_force_unit.sv
// ----------------------------------------------------------------------------
// obstacle_avoidance_force_unit
// Boid obstacle avoidance force, summed over a stream of obstacles.
//
//   channel  signals                      moves
//   in       in_valid / in_ready          one obstacle word per handshake
//   out      out_valid / out_ready        summed force word on last obstacle
//   cfg      cfg_we / cfg_wdata           boid radius
//
// Per word: a pop, 3 squares, a (COORD_WIDTH+6)-bit root and a check; in
// reach, 3 or 4 divides, then 3 adds (inside) or a smoothstep and 3
// multiply-add passes (outside); the last word then takes an emit step.
// Reset clears the sums and sets boid radius to 256. A two-word queue lets
// input run ahead; a held result word stalls only the next emit.
// ----------------------------------------------------------------------------
module obstacle_avoidance_force_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [oaf_pkg::RADIUS_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       boid_x,
    input  logic signed [COORD_WIDTH-1:0]       boid_y,
    input  logic signed [COORD_WIDTH-1:0]       boid_z,
    input  logic signed [COORD_WIDTH-1:0]       obstacle_x,
    input  logic signed [COORD_WIDTH-1:0]       obstacle_y,
    input  logic signed [COORD_WIDTH-1:0]       obstacle_z,
    input  logic [oaf_pkg::RADIUS_W-1:0]        obstacle_radius,
    input  logic                                last_obstacle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [oaf_pkg::FORCE_W-1:0]  force_x,
    output logic signed [oaf_pkg::FORCE_W-1:0]  force_y,
    output logic signed [oaf_pkg::FORCE_W-1:0]  force_z
);

    localparam int EW = 3 * (COORD_WIDTH + 1) + 3 + oaf_pkg::RADIUS_W + 1;

    logic [oaf_pkg::RADIUS_W-1:0] boid_radius_reg;
    logic [EW-1:0]                entry, q_data;
    logic                         q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boid_radius_reg <= oaf_pkg::BOID_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            boid_radius_reg <= cfg_wdata;
        end
    end

    oaf_front #(.W(COORD_WIDTH)) u_front (
        .boid_x          (boid_x),
        .boid_y          (boid_y),
        .boid_z          (boid_z),
        .obstacle_x      (obstacle_x),
        .obstacle_y      (obstacle_y),
        .obstacle_z      (obstacle_z),
        .obstacle_radius (obstacle_radius),
        .last_obstacle   (last_obstacle),
        .entry           (entry)
    );

    oaf_queue #(.WIDTH(EW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    oaf_seq #(.W(COORD_WIDTH)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .boid_radius (boid_radius_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .force_x     (force_x),
        .force_y     (force_y),
        .force_z     (force_z)
    );

endmodule

>>> test/obstacle_avoidance_force_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoidance_force_unit_tb
// Drives obstacle words with random bursts and gaps and stalls the result
// side on its own pattern. A local fixed-point predictor computes each
// summed force word, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module obstacle_avoidance_force_unit_tb;

    localparam int CW = 16;
    localparam int FW = oaf_pkg::FORCE_W;
    localparam int RW = oaf_pkg::RADIUS_W;
    localparam int CFG_BOID_RADIUS = 0;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic signed [FW-1:0] fx;
        logic signed [FW-1:0] fy;
        logic signed [FW-1:0] fz;
    } force_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [RW-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] boid_x = '0, boid_y = '0, boid_z = '0;
    logic signed [CW-1:0] obstacle_x = '0, obstacle_y = '0, obstacle_z = '0;
    logic [RW-1:0] obstacle_radius = '0;
    logic last_obstacle = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [FW-1:0] force_x, force_y, force_z;

    logic [RW-1:0] pred_boid_radius;
    longint pred_sum [3];
    force_word_t expected_forces [$];
    int mismatches = 0;
    int cycles = 0;
    bit stall_mode = 1'b0;

    obstacle_avoidance_force_unit #(.COORD_WIDTH(CW)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .boid_x(boid_x), .boid_y(boid_y), .boid_z(boid_z),
        .obstacle_x(obstacle_x), .obstacle_y(obstacle_y), .obstacle_z(obstacle_z),
        .obstacle_radius(obstacle_radius), .last_obstacle(last_obstacle),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .force_z(force_z)
    );

    always #10 clk = ~clk;

    function automatic longint clamp_force(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, rem, trial;
        root = 0;
        rem = 0;
        for (int i = 31; i >= 0; i--)
        begin
            rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem -= trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // applies one obstacle to the running sum
    task automatic apply_obstacle(input logic signed [CW-1:0] b [3],
                                  input logic signed [CW-1:0] o [3],
                                  input logic [RW-1:0] rad, input logic last);
        longint d [3];
        longint unsigned mag [3], u [3];
        longint unsigned sq, distance, avoid, rad12, t, s, m;
        force_word_t w;
        sq = 0;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = longint'(o[k]) - longint'(b[k]);
            mag[k] = d[k] < 0 ? -d[k] : d[k];
            sq += mag[k] * mag[k];
        end
        distance = int_sqrt(sq << 8);
        rad12 = longint'(rad) << 4;
        avoid = (longint'(pred_boid_radius) + 2 * longint'(rad)) << 4;
        if (distance != 0 && distance <= avoid)
        begin
            for (int k = 0; k < 3; k++)
                u[k] = (mag[k] << 16) / distance;
            if (distance < rad12)
            begin
                for (int k = 0; k < 3; k++)
                    pred_sum[k] = clamp_force(pred_sum[k] + (d[k] < 0 ? longint'(u[k])
                                                                    : -longint'(u[k])));
            end
            else if (avoid != 0)
            begin
                t = ((avoid - distance) << 12) / avoid;
                s = (t * t * (3 * 4096 - 2 * t)) >> 24;
                for (int k = 0; k < 3; k++)
                begin
                    m = (u[k] * rad * s) >> 20;
                    pred_sum[k] = clamp_force(pred_sum[k] + (d[k] < 0 ? longint'(m)
                                                                    : -longint'(m)));
                end
            end
        end
        if (last)
        begin
            w.fx = pred_sum[0][FW-1:0];
            w.fy = pred_sum[1][FW-1:0];
            w.fz = pred_sum[2][FW-1:0];
            expected_forces.push_back(w);
            for (int k = 0; k < 3; k++)
                pred_sum[k] = 0;
        end
    endtask

    // valid stays high after acceptance until the next word or drop_valid
    task automatic send_obstacle(input logic signed [CW-1:0] b [3],
                                 input logic signed [CW-1:0] o [3],
                                 input logic [RW-1:0] rad, input logic last);
        @(negedge clk);
        boid_x <= b[0]; boid_y <= b[1]; boid_z <= b[2];
        obstacle_x <= o[0]; obstacle_y <= o[1]; obstacle_z <= o[2];
        obstacle_radius <= rad;
        last_obstacle <= last;
        in_valid <= 1'b1;
        apply_obstacle(b, o, rad, last);
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_boid_radius(input logic [RW-1:0] value);
        wait (expected_forces.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        if (CFG_BOID_RADIUS == 0)
            pred_boid_radius = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random obstacle near the boid so most words land in reach
    task automatic send_random(input int spread, input logic last);
        logic signed [CW-1:0] b [3], o [3];
        logic [RW-1:0] rad;
        for (int k = 0; k < 3; k++)
        begin
            b[k] = CW'($urandom);
            if (spread == 0)
                o[k] = CW'($urandom);
            else
                o[k] = CW'(b[k] + $signed($urandom_range(0, 2 * spread)) - spread);
        end
        rad = ($urandom_range(0, 15) == 0) ? RW'($urandom)
                                           : RW'($urandom_range(0, 2047));
        send_obstacle(b, o, rad, last);
    endtask

    task automatic test_directed();
        logic signed [CW-1:0] b [3], o [3];
        b = '{16'sd0, 16'sd0, 16'sd0};
        o = '{16'sd0, 16'sd0, 16'sd0};
        send_obstacle(b, o, 15'd100, 1'b1);                  // zero distance
        o = '{16'sd256, 16'sd0, 16'sd0};
        send_obstacle(b, o, 15'd512, 1'b1);                  // inside
        o = '{16'sd0, -16'sd768, 16'sd0};
        send_obstacle(b, o, 15'd256, 1'b1);                  // in reach, outside
        o = '{16'sd0, 16'sd0, 16'sd768};
        send_obstacle(b, o, 15'd256, 1'b1);                  // exactly at avoid radius
        o = '{16'sd2000, 16'sd0, 16'sd0};
        send_obstacle(b, o, 15'd10, 1'b1);                   // beyond reach
        b = '{16'sh8000, 16'sh8000, 16'sh8000};
        o = '{16'sd32767, 16'sd32767, 16'sd32767};
        send_obstacle(b, o, 15'h7fff, 1'b1);                 // field extremes
        b = '{16'sh8000, 16'sd0, 16'sd0};
        o = '{16'sd32767, 16'sd0, 16'sd0};
        send_obstacle(b, o, 15'h7fff, 1'b1);                 // widest offset in reach
        b = '{16'sd0, 16'sd0, 16'sd0};
        o = '{16'sd32767, 16'sd0, 16'sd0};
        for (int i = 0; i < 40; i++)                          // saturate low
            send_obstacle(b, o, 15'h7fff, i == 39);
        o = '{-16'sd32767, 16'sd0, 16'sd0};
        for (int i = 0; i < 40; i++)                          // saturate high
            send_obstacle(b, o, 15'h7fff, i == 39);
        drop_valid();
    endtask

    task automatic test_random(input int words);
        for (int i = 0; i < words; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drop_valid();
                repeat ($urandom_range(0, 59)) @(negedge clk);
            end
            send_random($urandom_range(0, 9) == 0 ? 0 : 1 << $urandom_range(4, 12),
                        $urandom_range(0, 3) == 0);
        end
        send_random(256, 1'b1);
        drop_valid();
    endtask

    task automatic test_boid_radius();
        write_boid_radius(15'd0);
        test_random(60);
        write_boid_radius(15'h7fff);
        test_random(60);
        write_boid_radius(RW'($urandom));
        test_random(60);
        write_boid_radius(15'd256);
    endtask

    always @(negedge clk)
    begin
        if (cycles % 500 == 0)
            stall_mode <= $urandom_range(0, 2) != 0;
        out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        force_word_t w;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected force word %0d %0d %0d", force_x, force_y, force_z);
            end
            else
            begin
                w = expected_forces.pop_front();
                if (force_x !== w.fx || force_y !== w.fy || force_z !== w.fz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch exp %0d %0d %0d got %0d %0d %0d",
                                 w.fx, w.fy, w.fz, force_x, force_y, force_z);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= TIMEOUT_CYCLES)
        begin
            $display("[obstacle_avoidance_force_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        pred_boid_radius = oaf_pkg::BOID_RADIUS_RST;
        for (int k = 0; k < 3; k++)
            pred_sum[k] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(370);
        test_boid_radius();
        wait (expected_forces.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_forces.size() == 0)
            $display("[obstacle_avoidance_force_unit] OK");
        else
            $display("[obstacle_avoidance_force_unit] ERROR");
        $finish;
    end

endmodule
